/* rtl/mep_pkg.sv */
// Package for the Mandelbrot escape-time pixel unit: word types, register
// indexes, reset values and the saturation helper. No dependencies.
package mep_pkg;

	localparam int PIX_W          = 12;
	localparam int COORD_BITS_DEF = 12;
	localparam int FRAC_BITS_DEF  = 28;
	localparam int CNT_W          = 16;
	localparam int LEVEL_W        = 8;
	localparam int QDEPTH         = 2;
	localparam int CFG_IDX_W      = 3;

	localparam logic [CFG_IDX_W-1:0] REG_REAL_ORIGIN = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAG_ORIGIN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_REAL_STEP   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_IMAG_STEP   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ITER_LIMIT  = 3'd4;

	localparam logic [31:0]      RST_REAL_ORIGIN = 32'hDC000000;
	localparam logic [31:0]      RST_IMAG_ORIGIN = 32'hF0400000;
	localparam logic [31:0]      RST_REAL_STEP   = 32'd489335;
	localparam logic [31:0]      RST_IMAG_STEP   = 32'd489335;
	localparam logic [CNT_W-1:0] RST_ITER_LIMIT  = 16'd256;

	localparam logic [31:0]        COLOR_INSIDE = 32'h000000FF;
	localparam logic [LEVEL_W-1:0] ALPHA_OPAQUE = 8'hFF;

	typedef struct packed {
		logic [PIX_W-1:0] pixel_col;
		logic [PIX_W-1:0] pixel_row;
	} pix_word_t;

	typedef struct packed {
		logic [PIX_W-1:0] out_col;
		logic [PIX_W-1:0] out_row;
		logic [CNT_W-1:0] escape_count;
		logic             inside_set;
		logic [31:0]      rgba_color;
	} res_word_t;

	typedef struct packed {
		logic [31:0]      real_origin;
		logic [31:0]      imag_origin;
		logic [31:0]      real_step;
		logic [31:0]      imag_step;
		logic [CNT_W-1:0] iteration_limit;
	} cfg_t;

	typedef struct packed {
		logic [PIX_W-1:0] col;
		logic [PIX_W-1:0] row;
		logic [31:0]      cr;
		logic [31:0]      ci;
	} job_t;

	typedef struct packed {
		logic [PIX_W-1:0] col;
		logic [PIX_W-1:0] row;
		logic [CNT_W-1:0] count;
	} shade_req_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic hi_zero;
		logic hi_ones;
		logic signed [31:0] r;
		hi_zero = ~|v[63:31];
		hi_ones = &v[63:31];
		if (hi_zero || hi_ones) begin
			r = v[31:0];
		end else if (v[63]) begin
			r = 32'sh80000000;
		end else begin
			r = 32'sh7FFFFFFF;
		end
		return r;
	endfunction

endpackage

/* rtl/mep_front.sv */
// Front end: configuration registers, pixel word intake and mapping of the
// pixel index to the complex point c. Depends on mep_pkg.
module mep_front #(
	parameter int COORD_BITS = mep_pkg::COORD_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [mep_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [31:0]                    cfg_wdata,
	input  logic                           pix_valid,
	output logic                           pix_ready,
	input  mep_pkg::pix_word_t             pix_word,
	output logic                           job_valid,
	input  logic                           job_ready,
	output mep_pkg::job_t                  job,
	output mep_pkg::cfg_t                  cfg
);

	localparam int IDX_W  = (COORD_BITS < mep_pkg::PIX_W) ? COORD_BITS : mep_pkg::PIX_W;
	localparam int PROD_W = IDX_W + 33;

	mep_pkg::cfg_t cfg_q;
	logic          valid_s1;
	mep_pkg::job_t job_s1;

	logic [IDX_W-1:0]         col_idx;
	logic [IDX_W-1:0]         row_idx;
	logic signed [PROD_W-1:0] col_prod;
	logic signed [PROD_W-1:0] row_prod;
	logic signed [63:0]       cr_sum;
	logic signed [63:0]       ci_sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.real_origin     <= mep_pkg::RST_REAL_ORIGIN;
			cfg_q.imag_origin     <= mep_pkg::RST_IMAG_ORIGIN;
			cfg_q.real_step       <= mep_pkg::RST_REAL_STEP;
			cfg_q.imag_step       <= mep_pkg::RST_IMAG_STEP;
			cfg_q.iteration_limit <= mep_pkg::RST_ITER_LIMIT;
		end else if (cfg_we) begin
			case (cfg_idx)
				mep_pkg::REG_REAL_ORIGIN: cfg_q.real_origin     <= cfg_wdata;
				mep_pkg::REG_IMAG_ORIGIN: cfg_q.imag_origin     <= cfg_wdata;
				mep_pkg::REG_REAL_STEP:   cfg_q.real_step       <= cfg_wdata;
				mep_pkg::REG_IMAG_STEP:   cfg_q.imag_step       <= cfg_wdata;
				mep_pkg::REG_ITER_LIMIT:  cfg_q.iteration_limit <= cfg_wdata[mep_pkg::CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		col_idx  = pix_word.pixel_col[IDX_W-1:0];
		row_idx  = pix_word.pixel_row[IDX_W-1:0];
		col_prod = $signed({1'b0, col_idx}) * $signed(cfg_q.real_step);
		row_prod = $signed({1'b0, row_idx}) * $signed(cfg_q.imag_step);
		cr_sum   = 64'(col_prod) + 64'($signed(cfg_q.real_origin));
		ci_sum   = 64'(row_prod) + 64'($signed(cfg_q.imag_origin));
	end

	assign pix_ready = !valid_s1 || job_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pix_ready) begin
			valid_s1 <= pix_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_valid && pix_ready) begin
			job_s1.col <= pix_word.pixel_col;
			job_s1.row <= pix_word.pixel_row;
			job_s1.cr  <= mep_pkg::sat32(cr_sum);
			job_s1.ci  <= mep_pkg::sat32(ci_sum);
		end
	end

	assign job_valid = valid_s1;
	assign job       = job_s1;
	assign cfg       = cfg_q;

endmodule

/* rtl/mep_queue.sv */
// Short job queue between the front end and the iteration engine.
// Depends on mep_pkg.
module mep_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  mep_pkg::job_t push_job,
	output logic          pop_valid,
	input  logic          pop_ready,
	output mep_pkg::job_t pop_job
);

	localparam int PTR_W  = (mep_pkg::QDEPTH > 1) ? $clog2(mep_pkg::QDEPTH) : 1;
	localparam int FILL_W = $clog2(mep_pkg::QDEPTH + 1);

	mep_pkg::job_t    mem_q [mep_pkg::QDEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [FILL_W-1:0] fill_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = fill_q != FILL_W'(mep_pkg::QDEPTH);
	assign pop_valid  = fill_q != '0;
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_job    = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(mep_pkg::QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(mep_pkg::QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

/* rtl/mep_iter.sv */
// Iteration engine: runs z = z*z + c on one job until escape or limit.
// Products are registered, then the escape test and update follow.
// Depends on mep_pkg.
module mep_iter #(
	parameter int FRAC_BITS = mep_pkg::FRAC_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [mep_pkg::CNT_W-1:0]  limit,
	input  logic                       job_valid,
	output logic                       job_ready,
	input  mep_pkg::job_t              job,
	output logic                       req_valid,
	input  logic                       req_ready,
	output mep_pkg::shade_req_t        req
);

	localparam int          ESC_SHIFT = 2 * FRAC_BITS + 2;
	localparam bit          CAN_ESC   = (ESC_SHIFT <= 63);
	localparam logic [63:0] ESC_LIMIT = CAN_ESC ? (64'd1 << ESC_SHIFT) : '1;

	typedef enum logic [3:0] {
		IT_IDLE = 4'b0001,
		IT_MUL  = 4'b0010,
		IT_CHK  = 4'b0100,
		IT_DONE = 4'b1000
	} it_state_t;

	it_state_t state_q;

	logic [mep_pkg::PIX_W-1:0] col_q;
	logic [mep_pkg::PIX_W-1:0] row_q;
	logic signed [31:0]        cr_q;
	logic signed [31:0]        ci_q;
	logic signed [31:0]        zr_q;
	logic signed [31:0]        zi_q;
	logic [mep_pkg::CNT_W-1:0] count_q;
	logic signed [63:0]        rr_q;
	logic signed [63:0]        ii_q;
	logic signed [63:0]        ri_q;

	logic [63:0]        mag;
	logic               escaped;
	logic               finish;
	logic signed [63:0] diff;
	logic signed [63:0] nr;
	logic signed [63:0] ni;

	always_comb begin
		mag     = rr_q + ii_q;
		escaped = CAN_ESC && (mag > ESC_LIMIT);
		finish  = (count_q == limit) || escaped;
		diff    = rr_q - ii_q;
		nr      = (diff >>> FRAC_BITS) + 64'(cr_q);
		ni      = (ri_q >>> (FRAC_BITS - 1)) + 64'(ci_q);
	end

	assign job_ready = state_q == IT_IDLE;
	assign req_valid = state_q == IT_DONE;
	assign req.col   = col_q;
	assign req.row   = row_q;
	assign req.count = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IT_IDLE;
		end else begin
			case (state_q)
				IT_IDLE: if (job_valid) state_q <= IT_MUL;
				IT_MUL:  state_q <= IT_CHK;
				IT_CHK:  state_q <= finish ? IT_DONE : IT_MUL;
				IT_DONE: if (req_ready) state_q <= IT_IDLE;
				default: state_q <= IT_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			IT_IDLE: begin
				col_q   <= job.col;
				row_q   <= job.row;
				cr_q    <= $signed(job.cr);
				ci_q    <= $signed(job.ci);
				zr_q    <= '0;
				zi_q    <= '0;
				count_q <= '0;
			end
			IT_MUL: begin
				rr_q <= zr_q * zr_q;
				ii_q <= zi_q * zi_q;
				ri_q <= zr_q * zi_q;
			end
			IT_CHK: begin
				if (!finish) begin
					zr_q    <= mep_pkg::sat32(nr);
					zi_q    <= mep_pkg::sat32(ni);
					count_q <= count_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

endmodule

/* rtl/mep_shade.sv */
// Color stage: grey level = floor(count*255/limit) by an 8-step restoring
// divider, and the result word register. Depends on mep_pkg.
module mep_shade (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [mep_pkg::CNT_W-1:0]  limit,
	input  logic                       req_valid,
	output logic                       req_ready,
	input  mep_pkg::shade_req_t        req,
	output logic                       res_valid,
	input  logic                       res_ready,
	output mep_pkg::res_word_t         res_word
);

	localparam int NUM_W = mep_pkg::CNT_W + mep_pkg::LEVEL_W;
	localparam int BIT_W = $clog2(mep_pkg::LEVEL_W);

	typedef enum logic [2:0] {
		SH_IDLE = 3'b001,
		SH_DIV  = 3'b010,
		SH_HOLD = 3'b100
	} sh_state_t;

	sh_state_t state_q;

	logic [mep_pkg::PIX_W-1:0]   col_q;
	logic [mep_pkg::PIX_W-1:0]   row_q;
	logic [mep_pkg::CNT_W-1:0]   count_q;
	logic                        inside_q;
	logic [NUM_W-1:0]            rem_q;
	logic [mep_pkg::CNT_W-1:0]   div_q;
	logic [BIT_W-1:0]            bit_q;
	logic [mep_pkg::LEVEL_W-1:0] quo_q;

	logic             start;
	logic             at_limit;
	logic [NUM_W-1:0] trial;
	logic             fits;

	always_comb begin
		start    = (state_q == SH_IDLE) && req_valid;
		at_limit = req.count == limit;
		trial    = NUM_W'(div_q) << bit_q;
		fits     = rem_q >= trial;
	end

	assign req_ready = state_q == SH_IDLE;
	assign res_valid = state_q == SH_HOLD;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SH_IDLE;
		end else begin
			case (state_q)
				SH_IDLE: if (req_valid) state_q <= at_limit ? SH_HOLD : SH_DIV;
				SH_DIV:  if (bit_q == '0) state_q <= SH_HOLD;
				SH_HOLD: if (res_ready) state_q <= SH_IDLE;
				default: state_q <= SH_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			col_q    <= req.col;
			row_q    <= req.row;
			count_q  <= req.count;
			inside_q <= at_limit;
			rem_q    <= {req.count, mep_pkg::LEVEL_W'(0)} - NUM_W'(req.count);
			div_q    <= limit;
			bit_q    <= BIT_W'(mep_pkg::LEVEL_W - 1);
			quo_q    <= '0;
		end else if (state_q == SH_DIV) begin
			if (fits) begin
				rem_q        <= rem_q - trial;
				quo_q[bit_q] <= 1'b1;
			end
			bit_q <= bit_q - 1'b1;
		end
	end

	always_comb begin
		res_word.out_col      = col_q;
		res_word.out_row      = row_q;
		res_word.escape_count = count_q;
		res_word.inside_set   = inside_q;
		res_word.rgba_color   = inside_q ? mep_pkg::COLOR_INSIDE
			: {quo_q, quo_q, quo_q, mep_pkg::ALPHA_OPAQUE};
	end

endmodule

/* rtl/mandelbrot_escape_pixel_top.sv */
// Mandelbrot escape-time pixel unit, top level.
// Depends on mep_pkg, mep_front, mep_queue, mep_iter and mep_shade.
//
// Usage:
//   Configuration: write cfg_wdata to register cfg_idx while cfg_we is high
//   (0 real origin, 1 imaginary origin, 2 real step, 3 imaginary step,
//   4 iteration limit). Other indexes are ignored. Write only while idle.
//   Pixel channel: pix_valid/pix_ready carry one pixel word (column, row).
//   Result channel: res_valid/res_ready carry one result word per pixel, in
//   order: echoed column and row, escape count, inside flag, RGBA color.
//   Iteration: the engine spends a multiply state and a check state per
//   step, plus a final escape check for each word; the coloring divider
//   runs only for points outside the set, overlapped with the next word.
//   A two-entry queue sits after the mapping stage, so up to three pixel
//   words are taken while the engine is busy.
//   Reset: registers return to their defaults and all words in flight drop.
//   A stalled receiver holds the result word; the engine then waits and
//   the front keeps filling the queue until it is full.
module mandelbrot_escape_pixel_top #(
	parameter int COORD_BITS = mep_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = mep_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [mep_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [31:0]                   cfg_wdata,
	input  logic                          pix_valid,
	output logic                          pix_ready,
	input  mep_pkg::pix_word_t            pix_word,
	output logic                          res_valid,
	input  logic                          res_ready,
	output mep_pkg::res_word_t            res_word
);

	mep_pkg::cfg_t       cfg;
	logic                fq_valid;
	logic                fq_ready;
	mep_pkg::job_t       fq_job;
	logic                qi_valid;
	logic                qi_ready;
	mep_pkg::job_t       qi_job;
	logic                is_valid;
	logic                is_ready;
	mep_pkg::shade_req_t is_req;

	mep_front #(
		.COORD_BITS(COORD_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix_word  (pix_word),
		.job_valid (fq_valid),
		.job_ready (fq_ready),
		.job       (fq_job),
		.cfg       (cfg)
	);

	mep_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fq_valid),
		.push_ready (fq_ready),
		.push_job   (fq_job),
		.pop_valid  (qi_valid),
		.pop_ready  (qi_ready),
		.pop_job    (qi_job)
	);

	mep_iter #(
		.FRAC_BITS(FRAC_BITS)
	) u_iter (
		.clk       (clk),
		.arst_n    (arst_n),
		.limit     (cfg.iteration_limit),
		.job_valid (qi_valid),
		.job_ready (qi_ready),
		.job       (qi_job),
		.req_valid (is_valid),
		.req_ready (is_ready),
		.req       (is_req)
	);

	mep_shade u_shade (
		.clk       (clk),
		.arst_n    (arst_n),
		.limit     (cfg.iteration_limit),
		.req_valid (is_valid),
		.req_ready (is_ready),
		.req       (is_req),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_word  (res_word)
	);

endmodule

/* rtl/mep_checker.sv */
// Port-level checks on the result channel of the escape-time pixel unit,
// bound to the top level. Depends on mep_pkg.
module mep_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               res_valid,
	input logic               res_ready,
	input mep_pkg::res_word_t res_word
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_word))
		else $error("result word changed while stalled");

	a_inside_black: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_word.inside_set |-> res_word.rgba_color == mep_pkg::COLOR_INSIDE)
		else $error("inside point not opaque black");

	a_grey_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_word.inside_set |->
			res_word.rgba_color[7:0] == mep_pkg::ALPHA_OPAQUE &&
			res_word.rgba_color[31:24] == res_word.rgba_color[23:16] &&
			res_word.rgba_color[23:16] == res_word.rgba_color[15:8])
		else $error("grey level bytes differ or alpha not opaque");

	a_grey_below_white: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_word.inside_set |-> res_word.rgba_color[31:24] != 8'hFF)
		else $error("outside point reached full white");

endmodule

bind mandelbrot_escape_pixel_top mep_checker u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res_valid),
	.res_ready (res_ready),
	.res_word  (res_word)
);

/* tb/sv/tb_mandelbrot_escape_pixel_top.sv */
// Self-checking testbench for mandelbrot_escape_pixel_top: directed table, then random
// views of the complex plane under several idling phases, checked against a local model.
// Depends on mep_pkg and the mandelbrot_escape_pixel_top RTL.
`timescale 1ns / 100ps

module tb_mandelbrot_escape_pixel_top;
	import mep_pkg::*;

	localparam int FRAC = FRAC_BITS_DEF;
	localparam longint unsigned ESC_MAG = 64'd1 << (2 * FRAC + 2);
	localparam longint Q_MAX = 64'sd2147483647;
	localparam longint Q_MIN = -64'sd2147483648;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;
	localparam int SETTLE_CYCLES = 24;
	localparam int N_PHASES = 8;
	localparam int WORDS_PER_PHASE = 125;
	localparam int unsigned TICK_LIMIT = 4000000;
	localparam int N_DIR = 42;

	typedef enum logic {ROW_CFG, ROW_PIX} row_kind_e;

	typedef struct packed {
		row_kind_e            kind;
		logic [CFG_IDX_W-1:0] idx;
		logic [31:0]          data;
		pix_word_t            pix;
		logic                 given;
		res_word_t            want;
	} dir_row_t;

	logic                 clk;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx = '0;
	logic [31:0]          cfg_wdata = '0;
	logic                 pix_valid = 1'b0;
	logic                 pix_ready;
	pix_word_t            pix_word = '0;
	logic                 res_valid;
	logic                 res_ready = 1'b0;
	res_word_t            res_word;

	logic signed [31:0] re_org;
	logic signed [31:0] im_org;
	logic signed [31:0] re_step;
	logic signed [31:0] im_step;
	logic [CNT_W-1:0]   iter_lim;

	res_word_t   pending_shades [$];
	res_word_t   oldest;
	int          bad_words = 0;
	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;
	int unsigned tick_count = 0;

	dir_row_t dir_rows [N_DIR] = '{
		'{ROW_PIX, '0, 32'h0, '{12'd0, 12'd0}, 1'b0, '0},
		'{ROW_PIX, '0, 32'h0, '{12'd4095, 12'd4095}, 1'b0, '0},
		'{ROW_PIX, '0, 32'h0, '{12'd2048, 12'd1024}, 1'b0, '0},
		'{ROW_CFG, REG_UNUSED_LO, 32'hFFFFFFFF, '0, 1'b0, '0},
		'{ROW_CFG, REG_UNUSED_HI, 32'h00000000, '0, 1'b0, '0},
		'{ROW_PIX, '0, 32'h0, '{12'd1234, 12'd541}, 1'b0, '0},
		'{ROW_CFG, REG_ITER_LIMIT, 32'd0, '0, 1'b0, '0},
		'{ROW_PIX, '0, 32'h0, '{12'd17, 12'd300}, 1'b1,
			'{12'd17, 12'd300, 16'd0, 1'b1, 32'h000000FF}},
		'{ROW_PIX, '0, 32'h0, '{12'd4095, 12'd0}, 1'b1,
			'{12'd4095, 12'd0, 16'd0, 1'b1, 32'h000000FF}},
		'{ROW_CFG, REG_REAL_ORIGIN, 32'h0, '0, 1'b0, '0},
		'{ROW_CFG, REG_IMAG_ORIGIN, 32'h0, '0, 1'b0, '0},
		'{ROW_CFG, REG_REAL_STEP, 32'h0, '0, 1'b0, '0},
		'{ROW_CFG, REG_IMAG_STEP, 32'h0, '0, 1'b0, '0},
		'{ROW_CFG, REG_ITER_LIMIT, 32'd2, '0, 1'b0, '0},
		'{ROW_PIX, '0, 32'h0, '{12'd5, 12'd6}, 1'b1,
			'{12'd5, 12'd6, 16'd2, 1'b1, 32'h000000FF}},
		'{ROW_CFG, REG_REAL_ORIGIN, 32'h7FFFFFFF, '0, 1'b0, '0},
		'{ROW_PIX, '0, 32'h0, '{12'd0, 12'd4095}, 1'b1,
			'{12'd0, 12'd4095, 16'd1, 1'b0, 32'h7F7F7FFF}},
		'{ROW_CFG, REG_ITER_LIMIT, 32'd65535, '0, 1'b0, '0},
		'{ROW_CFG, REG_REAL_ORIGIN, 32'h80000000, '0, 1'b0, '0},
		'{ROW_PIX, '0, 32'h0, '{12'd3, 12'd4}, 1'b1,
			'{12'd3, 12'd4, 16'd1, 1'b0, 32'h000000FF}},
		'{ROW_CFG, REG_REAL_ORIGIN, 32'h0, '0, 1'b0, '0},
		'{ROW_PIX, '0, 32'h0, '{12'd9, 12'd9}, 1'b1,
			'{12'd9, 12'd9, 16'd65535, 1'b1, 32'h000000FF}},
		'{ROW_CFG, REG_ITER_LIMIT, 32'd1, '0, 1'b0, '0},
		'{ROW_PIX, '0, 32'h0, '{12'd100, 12'd200}, 1'b1,
			'{12'd100, 12'd200, 16'd1, 1'b1, 32'h000000FF}},
		'{ROW_CFG, REG_REAL_ORIGIN, 32'h7FFFFFFF, '0, 1'b0, '0},
		'{ROW_CFG, REG_REAL_STEP, 32'h7FFFFFFF, '0, 1'b0, '0},
		'{ROW_CFG, REG_IMAG_ORIGIN, 32'h80000000, '0, 1'b0, '0},
		'{ROW_CFG, REG_IMAG_STEP, 32'h80000000, '0, 1'b0, '0},
		'{ROW_CFG, REG_ITER_LIMIT, 32'd40, '0, 1'b0, '0},
		'{ROW_PIX, '0, 32'h0, '{12'd4095, 12'd4095}, 1'b0, '0},
		'{ROW_PIX, '0, 32'h0, '{12'd0, 12'd0}, 1'b0, '0},
		'{ROW_CFG, REG_REAL_STEP, 32'h80000000, '0, 1'b0, '0},
		'{ROW_CFG, REG_IMAG_STEP, 32'h7FFFFFFF, '0, 1'b0, '0},
		'{ROW_PIX, '0, 32'h0, '{12'd4095, 12'd4095}, 1'b0, '0},
		'{ROW_PIX, '0, 32'h0, '{12'd1, 12'd1}, 1'b0, '0},
		'{ROW_CFG, REG_REAL_ORIGIN, 32'hF4000000, '0, 1'b0, '0},
		'{ROW_CFG, REG_IMAG_ORIGIN, 32'h00800000, '0, 1'b0, '0},
		'{ROW_CFG, REG_REAL_STEP, 32'h00001000, '0, 1'b0, '0},
		'{ROW_CFG, REG_IMAG_STEP, 32'h00001000, '0, 1'b0, '0},
		'{ROW_CFG, REG_ITER_LIMIT, 32'd200, '0, 1'b0, '0},
		'{ROW_PIX, '0, 32'h0, '{12'd2047, 12'd2047}, 1'b0, '0},
		'{ROW_PIX, '0, 32'h0, '{12'd123, 12'd3000}, 1'b0, '0}
	};

	mandelbrot_escape_pixel_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix_word  (pix_word),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_word  (res_word)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic longint clamp_q(input longint v);
		if (v > Q_MAX) return Q_MAX;
		if (v < Q_MIN) return Q_MIN;
		return v;
	endfunction

	function automatic res_word_t shade_pixel(input pix_word_t p);
		longint      cr;
		longint      ci;
		longint      zr;
		longint      zi;
		longint      nr;
		longint      ni;
		int unsigned cnt;
		int unsigned lim;
		logic [7:0]  lvl;
		res_word_t   r;
		cr = clamp_q(longint'(re_org) + longint'(p.pixel_col) * longint'(re_step));
		ci = clamp_q(longint'(im_org) + longint'(p.pixel_row) * longint'(im_step));
		zr = 0;
		zi = 0;
		cnt = 0;
		lim = iter_lim;
		while (cnt < lim && (unsigned'(zr * zr) + unsigned'(zi * zi)) <= ESC_MAG) begin
			nr = ((zr * zr - zi * zi) >>> FRAC) + cr;
			ni = ((zr * zi) >>> (FRAC - 1)) + ci;
			zr = clamp_q(nr);
			zi = clamp_q(ni);
			cnt++;
		end
		r.out_col = p.pixel_col;
		r.out_row = p.pixel_row;
		r.escape_count = CNT_W'(cnt);
		r.inside_set = (cnt == lim);
		if (cnt == lim || lim == 0) begin
			r.rgba_color = 32'h000000FF;
		end else begin
			lvl = 8'((cnt * 255) / lim);
			r.rgba_color = {lvl, lvl, lvl, 8'hFF};
		end
		return r;
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		case (idx)
			REG_REAL_ORIGIN: re_org = data;
			REG_IMAG_ORIGIN: im_org = data;
			REG_REAL_STEP: re_step = data;
			REG_IMAG_STEP: im_step = data;
			REG_ITER_LIMIT: iter_lim = data[CNT_W-1:0];
			default: ;
		endcase
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// drop valid, drain every pending word, then let the pipeline settle
	task automatic wait_idle();
		pix_valid <= 1'b0;
		while (pending_shades.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic idle_gap();
		while ($urandom_range(99) < send_idle_pct) begin
			pix_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic send_pix(input pix_word_t w, input logic given, input res_word_t given_res);
		pix_valid <= 1'b1;
		pix_word <= w;
		do @(posedge clk); while (!pix_ready);
		pending_shades.push_back(given ? given_res : shade_pixel(w));
	endtask

	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready) begin
			if (pending_shades.size() == 0) begin
				$display("%0t ns: unexpected result word col %0d row %0d count %0d color %08h",
					$time, res_word.out_col, res_word.out_row, res_word.escape_count,
					res_word.rgba_color);
				bad_words++;
			end else begin
				oldest = pending_shades.pop_front();
				if (res_word !== oldest) begin
					$display("%0t ns: mismatch, expected col %0d row %0d count %0d inside %0b color %08h",
						$time, oldest.out_col, oldest.out_row, oldest.escape_count,
						oldest.inside_set, oldest.rgba_color);
					$display("%0t ns:           actual col %0d row %0d count %0d inside %0b color %08h",
						$time, res_word.out_col, res_word.out_row, res_word.escape_count,
						res_word.inside_set, res_word.rgba_color);
					bad_words++;
				end
			end
		end
		res_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		tick_count <= tick_count + 1;
		if (tick_count == TICK_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		logic [31:0] re_o;
		logic [31:0] im_o;
		logic [31:0] re_s;
		logic [31:0] im_s;
		logic [31:0] lim_w;
		pix_word_t   pw;
		re_org = 32'hDC000000;
		im_org = 32'hF0400000;
		re_step = 32'd489335;
		im_step = 32'd489335;
		iter_lim = 16'd256;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIR; i++) begin
			if (dir_rows[i].kind == ROW_CFG) begin
				wait_idle();
				write_reg(dir_rows[i].idx, dir_rows[i].data);
			end else begin
				send_pix(dir_rows[i].pix, dir_rows[i].given, dir_rows[i].want);
			end
		end

		for (int ph = 0; ph < N_PHASES; ph++) begin
			wait_idle();
			if (ph % 4 == 2) begin
				// arbitrary registers: most points escape at once, every bit toggles
				re_o = $urandom();
				im_o = $urandom();
				re_s = $urandom();
				im_s = $urandom();
				lim_w = $urandom_range(1, 64);
			end else begin
				// window over the set, from wide view down to deep zoom
				re_o = -32'sd671088640 + $urandom_range(0, 671088640);
				im_o = -32'sd335544320 + $urandom_range(0, 335544320);
				re_s = 32'($urandom_range(1, 196608) >> $urandom_range(0, 10));
				im_s = 32'($urandom_range(1, 196608) >> $urandom_range(0, 10));
				lim_w = (ph == 3) ? $urandom_range(1, 300) : $urandom_range(1, 128);
			end
			write_reg(REG_REAL_ORIGIN, re_o);
			write_reg(REG_IMAG_ORIGIN, im_o);
			write_reg(REG_REAL_STEP, re_s);
			write_reg(REG_IMAG_STEP, im_s);
			write_reg(REG_ITER_LIMIT, lim_w);
			write_reg(CFG_IDX_W'($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI)), $urandom());
			case (ph % 4)
				0: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
				1: begin
					send_idle_pct = 50;
					recv_idle_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_idle_pct = 50;
				end
				default: begin
					send_idle_pct = 11;
					recv_idle_pct = 11;
				end
			endcase
			for (int n = 0; n < WORDS_PER_PHASE; n++) begin
				idle_gap();
				pw.pixel_col = PIX_W'($urandom_range(0, 4095));
				pw.pixel_row = PIX_W'($urandom_range(0, 4095));
				send_pix(pw, 1'b0, '0);
			end
		end

		wait_idle();
		if (bad_words == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

/* mandelbrot_escape_pixel_top.f */
rtl/mep_pkg.sv
rtl/mep_front.sv
rtl/mep_queue.sv
rtl/mep_iter.sv
rtl/mep_shade.sv
rtl/mandelbrot_escape_pixel_top.sv
rtl/mep_checker.sv
tb/sv/tb_mandelbrot_escape_pixel_top.sv
